// File: design/rmpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpb_pkg
// Shared constants, types and controller/datapath interface structs for the
// row-major to vertical-page frame store.
// ----------------------------------------------------------------------------
package rmpb_pkg;

   // Display geometry (width is a power of two, multiple of 8)
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;

   // Column banks: bank k holds every column x with x % 8 == k
   localparam int BANK_COUNT     = 8;
   localparam int BANK_COLS      = DISPLAY_WIDTH / BANK_COUNT;
   localparam int BANK_DEPTH     = FRAME_BYTES / BANK_COUNT;
   localparam int BANK_AW        = $clog2(BANK_DEPTH);
   localparam int BANK_SEL_W     = $clog2(BANK_COUNT);

   // Field widths
   localparam int ROW_W          = 6;
   localparam int BCOL_W         = 4;
   localparam int PIX_W          = 8;
   localparam int AREA_W         = 7;
   localparam int INDEX_W        = 10;
   localparam int COL_W          = $clog2(DISPLAY_WIDTH + 1);
   localparam int HEIGHT_W       = $clog2(DISPLAY_HEIGHT + 1);
   localparam int FIDX_W         = $clog2(FRAME_BYTES + 1);

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_MERGE,
      ST_RESULT
   } rmpb_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;
      logic capture;
      logic fetch;
      logic merge;
      logic load_rsp;
   } rmpb_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic item_is_read;
      logic rsp_full;
   } rmpb_stat_type;

endpackage

// File: design/row_major_to_page_bitmap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_major_to_page_bitmap_unit
// Monochrome frame store in vertical 8-row pages, loaded from row-major
// pixel bytes and read back one frame byte at a time.
//
// Usage:
//   The req_ channel carries one word per item. A write word (operation 0)
//   spreads its eight pixels over eight column banks with one
//   read-modify-write per bank, inverted polarity, clipped to the area
//   bounds; it returns nothing. A read word (operation 1) returns the frame
//   byte at read_index on the rsp_ channel.
//   Each word passes through accept, bank read, then bank write-back or
//   loading of the result register; a new word is accepted only once the
//   last is through. A read result shows on rsp_valid once loaded into
//   the result register. After reset a clearing pass writes zero to all
//   banks, one row of eight bytes a cycle; req_ready stays low during it.
//   The result register waits on rsp_ready; a new word is accepted while a
//   result is still waiting, and only a second read result holds the block
//   until the first is taken.
// ----------------------------------------------------------------------------
module row_major_to_page_bitmap_unit
   import rmpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [ROW_W-1:0]    req_pixel_row,
   input  logic [BCOL_W-1:0]   req_byte_column,
   input  logic [PIX_W-1:0]    req_pixel_byte,
   input  logic [AREA_W-1:0]   req_area_left,
   input  logic [AREA_W-1:0]   req_area_right,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_frame_byte
);

   rmpb_cmd_type  cmd;
   rmpb_stat_type stat;

   // Sequencer
   rmpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Banks, merge and result register
   rmpb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_pixel_row   (req_pixel_row),
      .req_byte_column (req_byte_column),
      .req_pixel_byte  (req_pixel_byte),
      .req_area_left   (req_area_left),
      .req_area_right  (req_area_right),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte)
   );

endmodule

// File: design/rmpb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpb_ctrl
// Sequencer for the frame store: clearing pass after reset, then one word at
// a time through fetch, merge or result.
// ----------------------------------------------------------------------------
module rmpb_ctrl
   import rmpb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rmpb_stat_type stat,
   output rmpb_cmd_type  cmd
);

   rmpb_state_type state_ff;
   rmpb_state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = stat.item_is_read ? ST_RESULT : ST_MERGE;
         end
         ST_MERGE: begin
            state_in = ST_IDLE;
         end
         ST_RESULT: begin
            if (!stat.rsp_full) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
         end
         ST_RESULT: begin
            cmd.load_rsp = !stat.rsp_full;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/rmpb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpb_datapath
// Eight column banks of frame bytes, the item registers, the per-bank
// read-modify-write merge and the result register.
// ----------------------------------------------------------------------------
module rmpb_datapath
   import rmpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rmpb_cmd_type        cmd,
   output rmpb_stat_type       stat,
   input  logic                req_operation,
   input  logic [ROW_W-1:0]    req_pixel_row,
   input  logic [BCOL_W-1:0]   req_byte_column,
   input  logic [PIX_W-1:0]    req_pixel_byte,
   input  logic [AREA_W-1:0]   req_area_left,
   input  logic [AREA_W-1:0]   req_area_right,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_frame_byte
);

   // Item registers
   logic                op_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [BCOL_W-1:0]   bcol_ff;
   logic [PIX_W-1:0]    pix_ff;
   logic [AREA_W-1:0]   left_ff;
   logic [AREA_W-1:0]   right_ff;
   logic [INDEX_W-1:0]  index_ff;

   // Clearing pass counter
   logic [BANK_AW-1:0]  clr_addr_ff;
   logic [BANK_AW-1:0]  clr_addr_in;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          rsp_byte_ff;
   logic [7:0]          rsp_byte_in;

   // Bank storage and registered read data
   logic [7:0]          bank_mem [BANK_COUNT][BANK_DEPTH];
   logic [7:0]          rd_data_ff [BANK_COUNT];

   logic [BANK_AW-1:0]  item_addr;
   logic [BANK_AW-1:0]  rd_addr;
   logic [BANK_AW-1:0]  wr_addr;
   logic [BANK_COUNT-1:0] bank_we;
   logic [7:0]          bank_wd [BANK_COUNT];
   logic [BANK_COUNT-1:0] pix_in_area;
   logic [7:0]          row_mask;
   logic                row_ok;
   logic [BANK_SEL_W-1:0] rd_bank;
   logic                index_ok;

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         row_ff   <= req_pixel_row;
         bcol_ff  <= req_byte_column;
         pix_ff   <= req_pixel_byte;
         left_ff  <= req_area_left;
         right_ff <= req_area_right;
         index_ff <= req_read_index;
      end
   end

   // Advance the clearing address
   assign clr_addr_in = cmd.clear ? clr_addr_ff + BANK_AW'(1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Bank address of the pixel byte: page row times bank columns plus byte column
   assign item_addr = BANK_AW'(32'(row_ff >> 3) * BANK_COLS + 32'(bcol_ff));
   assign rd_addr   = (op_ff == OP_READ) ? index_ff[BANK_SEL_W +: BANK_AW] : item_addr;
   assign wr_addr   = cmd.clear ? clr_addr_ff : item_addr;

   // Per-pixel area test and merged byte
   assign row_mask = 8'(1) << row_ff[2:0];
   assign row_ok   = HEIGHT_W'(row_ff) < HEIGHT_W'(DISPLAY_HEIGHT);

   always_comb begin
      logic [COL_W-1:0] x;
      for (int i = 0; i < BANK_COUNT; i++) begin
         x = COL_W'({bcol_ff, BANK_SEL_W'(i)});
         pix_in_area[i] = (x >= COL_W'(left_ff)) && (x <= COL_W'(right_ff))
                          && (x < COL_W'(DISPLAY_WIDTH)) && row_ok;
      end
   end

   always_comb begin
      for (int i = 0; i < BANK_COUNT; i++) begin
         if (cmd.clear) begin
            bank_we[i] = 1'b1;
            bank_wd[i] = 8'h00;
         end else begin
            bank_we[i] = cmd.merge && pix_in_area[i];
            // set pixel clears the frame bit, clear pixel sets it
            bank_wd[i] = pix_ff[PIX_W-1-i] ? (rd_data_ff[i] & ~row_mask)
                                           : (rd_data_ff[i] | row_mask);
         end
      end
   end

   // Bank write and registered read
   always_ff @(posedge clock) begin
      for (int b = 0; b < BANK_COUNT; b++) begin
         if (bank_we[b]) bank_mem[b][wr_addr] <= bank_wd[b];
         if (cmd.fetch) rd_data_ff[b] <= bank_mem[b][rd_addr];
      end
   end

   // Result selection
   assign rd_bank  = index_ff[BANK_SEL_W-1:0];
   assign index_ok = FIDX_W'(index_ff) < FIDX_W'(FRAME_BYTES);

   assign rsp_byte_in  = cmd.load_rsp ? (index_ok ? rd_data_ff[rd_bank] : 8'h00)
                                      : rsp_byte_ff;
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;

   // Status back to the controller
   assign stat.clear_done   = cmd.clear && (clr_addr_ff == BANK_AW'(BANK_DEPTH - 1));
   assign stat.item_is_read = (op_ff == OP_READ);
   assign stat.rsp_full     = rsp_valid_ff && !rsp_ready;

endmodule

// File: tb/row_major_to_page_bitmap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_major_to_page_bitmap_checker
// Watches both channels of the page frame store. It keeps its own copy of
// the frame image, merges each accepted write word into it, and queues the
// frame byte that each accepted read word must return. Each returned word
// is compared with the oldest queued byte.
// ----------------------------------------------------------------------------
module row_major_to_page_bitmap_checker
   import rmpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_operation,
   input  logic [ROW_W-1:0]    req_pixel_row,
   input  logic [BCOL_W-1:0]   req_byte_column,
   input  logic [PIX_W-1:0]    req_pixel_byte,
   input  logic [AREA_W-1:0]   req_area_left,
   input  logic [AREA_W-1:0]   req_area_right,
   input  logic [INDEX_W-1:0]  req_read_index,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [7:0]          rsp_frame_byte,
   output int                  error_count,
   output int                  pending_count
);

   // Predicted frame image, one byte per column per page
   logic [7:0] frame_image [FRAME_BYTES];
   // Frame bytes still owed by the block, oldest first
   logic [7:0] owed_frame_bytes [$];

   // Merge one row-major pixel byte into the page layout, inverted polarity
   function automatic void merge_pixel_byte(input logic [ROW_W-1:0]  row,
                                            input logic [BCOL_W-1:0] bcol,
                                            input logic [PIX_W-1:0]  pixels,
                                            input logic [AREA_W-1:0] left,
                                            input logic [AREA_W-1:0] right);
      int page;
      int column;
      int index;
      if (int'(row) >= DISPLAY_HEIGHT) return;
      page = int'(row) / 8;
      for (int i = 0; i < 8; i++) begin
         column = int'(bcol) * 8 + i;
         if (column < int'(left) || column > int'(right) || column >= DISPLAY_WIDTH)
            continue;
         index = page * DISPLAY_WIDTH + column;
         if (index >= FRAME_BYTES) continue;
         // a set source pixel clears the frame bit, a clear one sets it
         frame_image[index][row[2:0]] = ~pixels[7 - i];
      end
   endfunction

   // Frame byte at an index, zero past the end of the store
   function automatic logic [7:0] frame_byte_at(input logic [INDEX_W-1:0] index);
      if (int'(index) >= FRAME_BYTES) return 8'h00;
      return frame_image[int'(index)];
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      logic [7:0] owed_byte;
      if (reset) begin
         foreach (frame_image[i]) frame_image[i] = 8'h00;
         owed_frame_bytes.delete();
      end else begin
         // compare the result word before queuing anything new
         if (rsp_valid && rsp_ready) begin
            if (owed_frame_bytes.size() == 0) begin
               error_count++;
               $error("frame_byte: result word with no read pending, actual 0x%02h",
                      rsp_frame_byte);
            end else begin
               owed_byte = owed_frame_bytes.pop_front();
               if (rsp_frame_byte !== owed_byte) begin
                  error_count++;
                  $error("frame_byte mismatch: expected 0x%02h, actual 0x%02h",
                         owed_byte, rsp_frame_byte);
               end
            end
         end
         // predict the accepted request word
         if (req_valid && req_ready) begin
            if (req_operation == OP_WRITE)
               merge_pixel_byte(req_pixel_row, req_byte_column, req_pixel_byte,
                                req_area_left, req_area_right);
            else
               owed_frame_bytes.push_back(frame_byte_at(req_read_index));
         end
      end
      pending_count = owed_frame_bytes.size();
   end

endmodule

// File: tb/row_major_to_page_bitmap_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_major_to_page_bitmap_unit_test
// Drives the page frame store with directed pixel writes and frame reads
// (full, partial and empty areas, edge rows and columns), then with random
// words under random idling on both channels, a long result hold-off and a
// full drain. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module row_major_to_page_bitmap_unit_test;
   import rmpb_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 200;
   localparam int TAIL_CYCLES   = 8;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [ROW_W-1:0]    req_pixel_row;
   logic [BCOL_W-1:0]   req_byte_column;
   logic [PIX_W-1:0]    req_pixel_byte;
   logic [AREA_W-1:0]   req_area_left;
   logic [AREA_W-1:0]   req_area_right;
   logic [INDEX_W-1:0]  req_read_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [7:0]          rsp_frame_byte;

   int error_count;
   int pending_count;
   int cycle_count;

   // Idle odds in percent per word (sender) and per cycle (receiver)
   int sender_idle_odds;
   int receiver_stall_odds;
   logic hold_request;

   // Last written location, used to aim reads at live bytes
   logic [ROW_W-1:0]  last_row;
   logic [BCOL_W-1:0] last_bcol;

   row_major_to_page_bitmap_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pixel_row   (req_pixel_row),
      .req_byte_column (req_byte_column),
      .req_pixel_byte  (req_pixel_byte),
      .req_area_left   (req_area_left),
      .req_area_right  (req_area_right),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte)
   );

   row_major_to_page_bitmap_checker frame_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pixel_row   (req_pixel_row),
      .req_byte_column (req_byte_column),
      .req_pixel_byte  (req_pixel_byte),
      .req_area_left   (req_area_left),
      .req_area_right  (req_area_right),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drop valid for a number of cycles
   task automatic idle_sender(input int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Offer one word and hold it until accepted; returns at a falling edge
   task automatic send_word(input logic                op,
                            input logic [ROW_W-1:0]    row,
                            input logic [BCOL_W-1:0]   bcol,
                            input logic [PIX_W-1:0]    pixels,
                            input logic [AREA_W-1:0]   left,
                            input logic [AREA_W-1:0]   right,
                            input logic [INDEX_W-1:0]  index);
      if (sender_idle_odds > 0 && $urandom_range(0, 99) < sender_idle_odds)
         idle_sender($urandom_range(1, 12));
      req_operation   = op;
      req_pixel_row   = row;
      req_byte_column = bcol;
      req_pixel_byte  = pixels;
      req_area_left   = left;
      req_area_right  = right;
      req_read_index  = index;
      req_valid       = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random word: mostly writes over wide areas, reads aimed at written bytes
   task automatic send_random_word();
      logic [AREA_W-1:0]  left;
      logic [AREA_W-1:0]  right;
      logic [AREA_W-1:0]  swap;
      logic [INDEX_W-1:0] index;
      int                 pick;
      pick  = $urandom_range(0, 99);
      left  = AREA_W'($urandom_range(0, 127));
      right = AREA_W'($urandom_range(0, 127));
      index = INDEX_W'($urandom_range(0, 1023));
      if (pick < 60) begin
         // write, area full, ordered or unconstrained
         if (pick < 35) begin
            left  = '0;
            right = AREA_W'(DISPLAY_WIDTH - 1);
         end else if (pick < 52 && left > right) begin
            swap  = left;
            left  = right;
            right = swap;
         end
         last_row  = ROW_W'($urandom_range(0, 63));
         last_bcol = BCOL_W'($urandom_range(0, 15));
         send_word(OP_WRITE, last_row, last_bcol, PIX_W'($urandom_range(0, 255)),
                   left, right, index);
      end else begin
         // read near the last write, or anywhere
         if (pick < 85)
            index = INDEX_W'(int'(last_row / 8) * DISPLAY_WIDTH + int'(last_bcol) * 8
                             + int'($urandom_range(0, 7)));
         send_word(OP_READ, ROW_W'($urandom_range(0, 63)), BCOL_W'($urandom_range(0, 15)),
                   PIX_W'($urandom_range(0, 255)), left, right, index);
      end
   endtask

   // Pause the sender until every owed byte has come back
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Receiver: one long hold-off on request, random stall bursts otherwise
   initial begin
      logic hold_taken;
      rsp_ready  = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready  = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (receiver_stall_odds > 0 &&
                      $urandom_range(0, 99) < receiver_stall_odds) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = OP_WRITE;
      req_pixel_row       = '0;
      req_byte_column     = '0;
      req_pixel_byte      = '0;
      req_area_left       = '0;
      req_area_right      = '0;
      req_read_index      = '0;
      sender_idle_odds    = 0;
      receiver_stall_odds = 0;
      hold_request        = 1'b0;
      last_row            = '0;
      last_bcol           = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: cleared store, edge rows and columns, partial and empty areas
      send_word(OP_READ,  6'd0,  4'd0,  8'h00, 7'd0,   7'd127, 10'd0);
      send_word(OP_READ,  6'd0,  4'd0,  8'h00, 7'd0,   7'd127, 10'd1023);
      send_word(OP_WRITE, 6'd0,  4'd0,  8'h00, 7'd0,   7'd127, 10'd0);
      send_word(OP_READ,  6'd0,  4'd0,  8'h00, 7'd0,   7'd127, 10'd0);
      send_word(OP_READ,  6'd0,  4'd0,  8'h00, 7'd0,   7'd127, 10'd7);
      send_word(OP_WRITE, 6'd63, 4'd15, 8'h00, 7'd0,   7'd127, 10'd0);
      send_word(OP_READ,  6'd63, 4'd15, 8'hFF, 7'd0,   7'd127, 10'd1023);
      send_word(OP_READ,  6'd63, 4'd15, 8'hFF, 7'd0,   7'd127, 10'd1016);
      send_word(OP_WRITE, 6'd0,  4'd0,  8'hFF, 7'd0,   7'd127, 10'd0);
      send_word(OP_READ,  6'd0,  4'd0,  8'hFF, 7'd0,   7'd127, 10'd0);
      send_word(OP_WRITE, 6'd9,  4'd1,  8'h00, 7'd10,  7'd5,   10'd0);
      send_word(OP_READ,  6'd9,  4'd1,  8'h00, 7'd10,  7'd5,   10'd136);
      send_word(OP_WRITE, 6'd2,  4'd0,  8'hA5, 7'd3,   7'd5,   10'd0);
      send_word(OP_READ,  6'd2,  4'd0,  8'hA5, 7'd3,   7'd5,   10'd3);
      send_word(OP_READ,  6'd2,  4'd0,  8'hA5, 7'd3,   7'd5,   10'd5);
      send_word(OP_READ,  6'd2,  4'd0,  8'hA5, 7'd3,   7'd5,   10'd2);
      send_word(OP_WRITE, 6'd31, 4'd15, 8'hAA, 7'd127, 7'd127, 10'd0);
      send_word(OP_READ,  6'd31, 4'd15, 8'hAA, 7'd127, 7'd127, 10'd511);
      send_word(OP_WRITE, 6'd40, 4'd7,  8'h55, 7'd0,   7'd127, 10'd0);
      send_word(OP_READ,  6'd40, 4'd7,  8'h55, 7'd0,   7'd127, 10'd696);
      send_word(OP_READ,  6'd40, 4'd7,  8'h55, 7'd0,   7'd127, 10'd697);
      send_word(OP_WRITE, 6'd17, 4'd3,  8'h00, 7'd127, 7'd0,   10'd0);
      send_word(OP_READ,  6'd17, 4'd3,  8'h00, 7'd127, 7'd0,   10'd280);
      send_word(OP_READ,  6'd0,  4'd0,  8'h00, 7'd0,   7'd127, 10'd512);

      // Random, light idling
      sender_idle_odds    = 10;
      receiver_stall_odds = 5;
      repeat (400) send_random_word();

      // Hold off the receiver while reads keep coming, then drain
      sender_idle_odds = 0;
      hold_request     = 1'b1;
      repeat (40) begin
         send_word(OP_READ, ROW_W'($urandom_range(0, 63)), BCOL_W'($urandom_range(0, 15)),
                   PIX_W'($urandom_range(0, 255)), AREA_W'($urandom_range(0, 127)),
                   AREA_W'($urandom_range(0, 127)), INDEX_W'($urandom_range(0, 1023)));
      end
      drain_results();

      // Random, heavy idling
      sender_idle_odds    = 30;
      receiver_stall_odds = 15;
      repeat (500) send_random_word();

      // Random, no idling
      sender_idle_odds    = 0;
      receiver_stall_odds = 0;
      repeat (300) send_random_word();

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
design/rmpb_pkg.sv
design/rmpb_ctrl.sv
design/rmpb_datapath.sv
design/row_major_to_page_bitmap_unit.sv
tb/row_major_to_page_bitmap_checker.sv
tb/row_major_to_page_bitmap_unit_test.sv
